>>> rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the block pattern search core.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int PATTERN_MAX = 512;
    localparam int NUM_CELLS   = BLOCK_BYTES;
    localparam int IDX_W       = 9;
    localparam int LEN_W       = 10;
    localparam int BYTE_W      = 8;
    localparam int NUM_GROUPS  = 16;
    localparam int GROUP_SIZE  = NUM_CELLS / NUM_GROUPS;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef enum logic [0:0] {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_NEGATE_MODE    = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SPEC_NORMAL   = 2'd0,
        SPEC_LEN_ZERO = 2'd1,
        SPEC_LEN_OVER = 2'd2
    } spec_t;

    typedef struct packed {
        logic              data_en;
        logic              block_end;
        logic              load_en;
        logic              adv;
        logic              len_ok;
        logic              judge_en;
        logic              negate;
        logic [IDX_W-1:0]  len_m1;
        logic [IDX_W-1:0]  load_idx;
        logic [BYTE_W-1:0] data_byte;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/bps_cell.sv
// ----------------------------------------------------------------------------
// bps_cell
// One comparator cell: holds one pattern byte and the prefix flag of the
// window currently sitting at this pattern position.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [bps_pkg::IDX_W-1:0]  cell_index,
    input  wire bps_pkg::cell_ctrl_t        ctrl,
    input  wire logic                       flag_in,
    output logic                            flag_out,
    output logic                            hit_out
);

    logic [bps_pkg::BYTE_W-1:0] pattern_reg;
    logic                       flag_reg;
    logic                       flag_next;
    logic                       hit_reg;
    logic                       hit_next;
    logic                       active;
    logic                       judge;

    always_comb begin
        active    = ctrl.len_ok && (cell_index <= ctrl.len_m1);
        flag_next = active ? (flag_in && (ctrl.data_byte == pattern_reg)) : flag_in;
        judge     = ctrl.judge_en && (cell_index == ctrl.len_m1);
        hit_next  = ctrl.data_en && judge && (flag_next ^ ctrl.negate);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_en && (ctrl.load_idx == cell_index)) begin
            pattern_reg <= ctrl.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end else begin
            if (ctrl.data_en) begin
                flag_reg <= ctrl.block_end ? 1'b0 : flag_next;
            end
            if (ctrl.adv) begin
                hit_reg <= hit_next;
            end
        end
    end

    assign flag_out = flag_reg;
    assign hit_out  = hit_reg;

endmodule

`default_nettype wire

>>> rtl/block_pattern_search_core.sv
// ----------------------------------------------------------------------------
// block_pattern_search_core
// Byte pattern search over 512-byte blocks using a shifting row of cells.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while s_tready is high; each data byte
//   shifts the prefix flags one cell down the 512-cell comparator row.
// Result path: after the block's last byte is accepted, the result reaches
//   m_tvalid through the cell hit, group OR and output registers.
// s_tready drops only while a result waits in the output register and the
//   next block end has reached the last stage.
// Reset (aresetn low, synchronous): clears flags, position, hit state and
//   pipeline; pattern_length = 1, negate_mode = 0; pattern bytes undefined.
`default_nettype none

module block_pattern_search_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [0:0]                      cfg_wr_index,
    input  wire logic [bps_pkg::LEN_W-1:0]       cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bps_pkg::S_TDATA_W-1:0]   s_tdata,   // data_byte, pattern_index
    input  wire logic                            s_tuser,   // req_type
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bps_pkg::M_TDATA_W-1:0]        m_tdata    // found, match_offset
);

    logic [bps_pkg::LEN_W-1:0]      len_reg;
    logic                           neg_reg;
    logic [bps_pkg::IDX_W-1:0]      pos_reg;
    logic [bps_pkg::IDX_W-1:0]      pos_next;

    logic                           adv;
    logic                           accept;
    logic                           data_en;
    logic                           block_end;
    logic                           len_ok;
    logic [bps_pkg::LEN_W-1:0]      len_dec;
    logic [bps_pkg::IDX_W-1:0]      len_m1;
    logic                           judge_en;
    bps_pkg::spec_t                 spec0;
    bps_pkg::cell_ctrl_t            ctrl;

    logic [bps_pkg::NUM_CELLS-1:0]  flag_vec;
    logic [bps_pkg::NUM_CELLS-1:0]  hit_vec;

    logic                           end1_reg;
    bps_pkg::spec_t                 spec1_reg;
    logic                           neg1_reg;
    logic [bps_pkg::IDX_W-1:0]      off1_reg;

    logic                           end2_reg;
    bps_pkg::spec_t                 spec2_reg;
    logic                           neg2_reg;
    logic [bps_pkg::IDX_W-1:0]      off2_reg;
    logic [bps_pkg::NUM_GROUPS-1:0] grp_reg;
    logic [bps_pkg::NUM_GROUPS-1:0] grp_next;
    logic                           hit2;

    logic                           hit_seen_reg;
    logic [bps_pkg::IDX_W-1:0]      hit_off_reg;

    logic                           m_valid_reg;
    logic                           found_reg;
    logic                           found_next;
    logic [bps_pkg::IDX_W-1:0]      moff_reg;
    logic [bps_pkg::IDX_W-1:0]      moff_next;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= bps_pkg::LEN_W'(1);
            neg_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                bps_pkg::CFG_PATTERN_LENGTH: len_reg <= cfg_wr_data;
                bps_pkg::CFG_NEGATE_MODE:    neg_reg <= cfg_wr_data[0];
                default:                     len_reg <= len_reg;
            endcase
        end
    end

    // front end
    always_comb begin
        adv       = !(end2_reg && m_valid_reg && !m_tready);
        accept    = s_tvalid && adv;
        data_en   = accept && (s_tuser == bps_pkg::REQ_DATA);
        block_end = (pos_reg == bps_pkg::IDX_W'(bps_pkg::BLOCK_BYTES - 1));
        len_ok    = (len_reg != '0) && (len_reg <= bps_pkg::LEN_W'(bps_pkg::BLOCK_BYTES));
        len_dec   = len_reg - bps_pkg::LEN_W'(1);
        len_m1    = len_dec[bps_pkg::IDX_W-1:0];
        judge_en  = len_ok && (len_m1 <= pos_reg);
        pos_next  = block_end ? '0 : pos_reg + bps_pkg::IDX_W'(1);
        if (len_reg == '0) begin
            spec0 = bps_pkg::SPEC_LEN_ZERO;
        end else if (!len_ok) begin
            spec0 = bps_pkg::SPEC_LEN_OVER;
        end else begin
            spec0 = bps_pkg::SPEC_NORMAL;
        end
        ctrl.data_en   = data_en;
        ctrl.block_end = block_end;
        ctrl.load_en   = accept && (s_tuser == bps_pkg::REQ_LOAD);
        ctrl.adv       = adv;
        ctrl.len_ok    = len_ok;
        ctrl.judge_en  = judge_en;
        ctrl.negate    = neg_reg;
        ctrl.len_m1    = len_m1;
        ctrl.load_idx  = s_tdata[bps_pkg::BYTE_W +: bps_pkg::IDX_W];
        ctrl.data_byte = s_tdata[bps_pkg::BYTE_W-1:0];
    end

    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (data_en) begin
            pos_reg <= pos_next;
        end
    end

    // comparator row
    for (genvar k = 0; k < bps_pkg::NUM_CELLS; k++) begin : g_cell
        logic cell_flag_in;
        if (k == 0) begin : g_head
            assign cell_flag_in = len_ok;
        end else begin : g_body
            assign cell_flag_in = flag_vec[k-1];
        end
        bps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (bps_pkg::IDX_W'(k)),
            .ctrl       (ctrl),
            .flag_in    (cell_flag_in),
            .flag_out   (flag_vec[k]),
            .hit_out    (hit_vec[k])
        );
    end

    // stage 1: alongside the cell hit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end1_reg <= 1'b0;
        end else if (adv) begin
            end1_reg <= data_en && block_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            spec1_reg <= spec0;
            neg1_reg  <= neg_reg;
            off1_reg  <= pos_reg - len_m1;
        end
    end

    // stage 2: group OR
    always_comb begin
        for (int g = 0; g < bps_pkg::NUM_GROUPS; g++) begin
            grp_next[g] = |hit_vec[g*bps_pkg::GROUP_SIZE +: bps_pkg::GROUP_SIZE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end2_reg <= 1'b0;
            grp_reg  <= '0;
        end else if (adv) begin
            end2_reg <= end1_reg;
            grp_reg  <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            spec2_reg <= spec1_reg;
            neg2_reg  <= neg1_reg;
            off2_reg  <= off1_reg;
        end
    end

    // stage 3: hit tracking and result
    always_comb begin
        hit2 = |grp_reg;
        case (spec2_reg)
            bps_pkg::SPEC_LEN_ZERO: begin
                found_next = !neg2_reg;
                moff_next  = '0;
            end
            bps_pkg::SPEC_LEN_OVER: begin
                found_next = neg2_reg;
                moff_next  = '0;
            end
            default: begin
                found_next = hit_seen_reg || hit2;
                moff_next  = hit_seen_reg ? hit_off_reg : (hit2 ? off2_reg : '0);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_seen_reg <= 1'b0;
            hit_off_reg  <= '0;
        end else if (adv) begin
            if (end2_reg) begin
                hit_seen_reg <= 1'b0;
                hit_off_reg  <= '0;
            end else if (hit2 && !hit_seen_reg) begin
                hit_seen_reg <= 1'b1;
                hit_off_reg  <= off2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && end2_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && end2_reg) begin
            found_reg <= found_next;
            moff_reg  <= moff_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(bps_pkg::M_TDATA_W - bps_pkg::IDX_W - 1)'(0), moff_reg, found_reg};

`ifndef SYNTH
    a_result_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(end2_reg))
        else $error("result item without a block end");

    a_single_judge: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("more than one cell judged a window");

    a_single_group: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(grp_reg))
        else $error("more than one group hit");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> (m_valid_reg && end2_reg))
        else $error("stall without a waiting result");

    a_stall_holds_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (end2_reg && !adv) |=> end2_reg)
        else $error("block end lost during stall");
`endif

endmodule

`default_nettype wire
